FILE: src/tdpq_pkg.sv
// ----------------------------------------------------------------------------
// tdpq_pkg
// Shared types and constants for the tail-drop port queue.
// ----------------------------------------------------------------------------
package tdpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BYTE_W      = $clog2(QUEUE_DEPTH * 65536);

  localparam int TAG_W       = 16;
  localparam int LEN_W       = 16;
  localparam int ENTRY_W     = TAG_W + LEN_W;

  localparam int PKT_LIM_W   = 7;
  localparam int BYTE_LIM_W  = 22;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [31:0] PKT_FIELD_MAX  = 32'd127;
  localparam logic [31:0] BYTE_FIELD_MAX = 32'd4194303;

  typedef enum logic [1:0] {
    OP_PACKET  = 2'd0,
    OP_DONE    = 2'd1,
    OP_CONTROL = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_QUEUED  = 3'd1,
    ACT_DROPPED = 3'd2,
    ACT_IDLE    = 3'd3,
    ACT_CONTROL = 3'd4
  } action_t;

  typedef enum logic {
    REG_PACKET_LIMIT = 1'b0,
    REG_BYTE_LIMIT   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PKT_LIM_W-1:0]  packet_limit;
    logic [BYTE_LIM_W-1:0] byte_limit;
  } cfg_t;

endpackage

FILE: src/tdpq_ram.sv
// ----------------------------------------------------------------------------
// tdpq_ram
// Simple dual-port RAM, one write port and one read port with registered
// read data (read-first on address collision).
// ----------------------------------------------------------------------------
module tdpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tdpq_regs.sv
// ----------------------------------------------------------------------------
// tdpq_regs
// APB-style configuration registers: packet limit and byte limit.
// ----------------------------------------------------------------------------
module tdpq_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdpq_pkg::PADDR_W-1:0]  paddr,
  input  logic [tdpq_pkg::PDATA_W-1:0]  pwdata,
  output logic [tdpq_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output tdpq_pkg::cfg_t                cfg
);

  tdpq_pkg::cfg_t   cfg_r;
  tdpq_pkg::cfg_t   cfg_nxt;
  logic             wr_en;
  logic             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        tdpq_pkg::REG_PACKET_LIMIT: begin
          cfg_nxt.packet_limit = pwdata[tdpq_pkg::PKT_LIM_W-1:0];
        end
        tdpq_pkg::REG_BYTE_LIMIT: begin
          cfg_nxt.byte_limit = pwdata[tdpq_pkg::BYTE_LIM_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      tdpq_pkg::REG_PACKET_LIMIT: begin
        prdata = tdpq_pkg::PDATA_W'(cfg_r.packet_limit);
      end
      tdpq_pkg::REG_BYTE_LIMIT: begin
        prdata = tdpq_pkg::PDATA_W'(cfg_r.byte_limit);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: src/tail_drop_port_queue_unit.sv
// ----------------------------------------------------------------------------
// tail_drop_port_queue_unit
// Egress port queue: busy flag plus a FIFO of packet tags and lengths with
// packet-count and byte-count tail-drop limits.
// Input register at accept, result register when the input stage fires (held
// while a result waits). Throughput: one request per cycle while results are
// taken, set by the single update of queue state per cycle; the head entry is
// held in registers and the next is prefetched from the RAM's registered port.
// Reset (synchronous, rst_n low): transmitter idle, queue empty, limits 0.
// ----------------------------------------------------------------------------
module tail_drop_port_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [15:0]                   in_packet_tag,
  input  logic [15:0]                   in_packet_length,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_action,
  output logic [15:0]                   out_tag,
  output logic [15:0]                   out_length,
  output logic [6:0]                    out_queued_packets,
  output logic [21:0]                   out_queued_bytes,
  output logic                          out_busy_res,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdpq_pkg::PADDR_W-1:0]  paddr,
  input  logic [tdpq_pkg::PDATA_W-1:0]  pwdata,
  output logic [tdpq_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int PTR_W   = tdpq_pkg::PTR_W;
  localparam int CNT_W   = tdpq_pkg::CNT_W;
  localparam int BYTE_W  = tdpq_pkg::BYTE_W;
  localparam int ENTRY_W = tdpq_pkg::ENTRY_W;

  tdpq_pkg::cfg_t cfg;

  // input stage
  logic                       s1_valid_r;
  logic [1:0]                 s1_op_r;
  logic [15:0]                s1_tag_r;
  logic [15:0]                s1_len_r;
  logic                       s1_fire;
  logic                       out_free;

  // queue state
  logic                       busy_r, busy_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]          bytes_r, bytes_nxt;
  logic [PTR_W-1:0]           hd_ptr_r, hd_ptr_nxt;
  logic [PTR_W-1:0]           tl_ptr_r, tl_ptr_nxt;
  logic [ENTRY_W-1:0]         hd_data_r, hd_data_nxt;
  logic                       byp_r, byp_nxt;
  logic [ENTRY_W-1:0]         byp_data_r;

  // memory port
  logic                       ram_we;
  logic [ENTRY_W-1:0]         ram_wdata;
  logic [PTR_W-1:0]           ram_raddr;
  logic [ENTRY_W-1:0]         ram_rdata;
  logic [ENTRY_W-1:0]         second;

  // result
  tdpq_pkg::action_t          act;
  logic [15:0]                res_tag;
  logic [15:0]                res_len;
  logic                       drop;

  logic                       out_valid_r;
  tdpq_pkg::action_t          out_action_r;
  logic [15:0]                out_tag_r;
  logic [15:0]                out_length_r;
  logic [6:0]                 out_pkts_r;
  logic [21:0]                out_bytes_r;
  logic                       out_busy_r;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(tdpq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  tdpq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (tdpq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tl_ptr_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  assign second    = byp_r ? byp_data_r : ram_rdata;
  assign ram_wdata = {s1_tag_r, s1_len_r};

  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    bytes_nxt   = bytes_r;
    hd_ptr_nxt  = hd_ptr_r;
    tl_ptr_nxt  = tl_ptr_r;
    hd_data_nxt = hd_data_r;
    ram_we      = 1'b0;
    act         = tdpq_pkg::ACT_CONTROL;
    res_tag     = s1_tag_r;
    res_len     = '0;
    drop        = 1'b0;
    if (s1_fire) begin
      case (s1_op_r)
        tdpq_pkg::OP_PACKET: begin
          res_len = s1_len_r;
          if (!busy_r) begin
            busy_nxt = 1'b1;
            act      = tdpq_pkg::ACT_START;
          end else begin
            drop = (32'(cnt_r) >= 32'(tdpq_pkg::QUEUE_DEPTH))
                || ((cfg.packet_limit != '0)
                    && (32'(cnt_r) >= 32'(cfg.packet_limit)))
                || ((cfg.byte_limit != '0)
                    && ((32'(bytes_r) + 32'(s1_len_r)) > 32'(cfg.byte_limit)));
            if (drop) begin
              act = tdpq_pkg::ACT_DROPPED;
            end else begin
              act        = tdpq_pkg::ACT_QUEUED;
              ram_we     = 1'b1;
              tl_ptr_nxt = next_slot(tl_ptr_r);
              cnt_nxt    = cnt_r + 1'b1;
              bytes_nxt  = bytes_r + BYTE_W'(s1_len_r);
              if (cnt_r == '0) begin
                hd_data_nxt = {s1_tag_r, s1_len_r};
              end
            end
          end
        end
        tdpq_pkg::OP_DONE: begin
          if (cnt_r == '0) begin
            busy_nxt = 1'b0;
            act      = tdpq_pkg::ACT_IDLE;
            res_tag  = '0;
            res_len  = '0;
          end else begin
            act         = tdpq_pkg::ACT_START;
            res_tag     = hd_data_r[ENTRY_W-1 -: 16];
            res_len     = hd_data_r[15:0];
            busy_nxt    = 1'b1;
            hd_ptr_nxt  = next_slot(hd_ptr_r);
            cnt_nxt     = cnt_r - 1'b1;
            bytes_nxt   = bytes_r - BYTE_W'(hd_data_r[15:0]);
            hd_data_nxt = second;
          end
        end
        default: begin
          act     = tdpq_pkg::ACT_CONTROL;
          res_tag = s1_tag_r;
          res_len = '0;
        end
      endcase
    end
  end

  // prefetch the entry behind the head; catch a write that races the read
  assign ram_raddr = next_slot(hd_ptr_nxt);
  assign byp_nxt   = ram_we && (tl_ptr_r == ram_raddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      bytes_r     <= '0;
      hd_ptr_r    <= '0;
      tl_ptr_r    <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      bytes_r  <= bytes_nxt;
      hd_ptr_r <= hd_ptr_nxt;
      tl_ptr_r <= tl_ptr_nxt;
      byp_r    <= byp_nxt;
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r  <= in_op;
      s1_tag_r <= in_packet_tag;
      s1_len_r <= in_packet_length;
    end
    hd_data_r  <= hd_data_nxt;
    byp_data_r <= ram_wdata;
    if (s1_fire) begin
      out_action_r <= act;
      out_tag_r    <= res_tag;
      out_length_r <= res_len;
      out_pkts_r   <= (32'(cnt_nxt) > tdpq_pkg::PKT_FIELD_MAX) ? 7'h7f : 7'(cnt_nxt);
      out_bytes_r  <= (32'(bytes_nxt) > tdpq_pkg::BYTE_FIELD_MAX) ? 22'h3fffff
                    : 22'(bytes_nxt);
      out_busy_r   <= busy_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_tag            = out_tag_r;
  assign out_length         = out_length_r;
  assign out_queued_packets = out_pkts_r;
  assign out_queued_bytes   = out_bytes_r;
  assign out_busy_res       = out_busy_r;

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cnt_r == '0))
    else $error("queue holds packets while transmitter idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(tdpq_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_action_r == tdpq_pkg::ACT_IDLE))
      |-> (!out_busy_r && (out_pkts_r == '0)))
    else $error("idle result with busy flag or queued packets");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (hd_ptr_r == tl_ptr_r))
    else $error("pointers differ on empty queue");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tail-drop port queue. Requests (packets,
// transmit-done events, control messages) go in with random gaps, results
// are taken with random backpressure and compared field by field against a
// cycle-free model of the busy flag, the FIFO and the count and byte limits.
// Limits are reprogrammed over APB between phases while the queue is quiet.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct {
    tdpq_pkg::action_t action;
    logic [15:0]       tag;
    logic [15:0]       length;
    logic [6:0]        packets;
    logic [21:0]       bytes;
    logic              busy;
  } queue_result_t;

  class port_queue_model;
    bit            tx_busy;
    logic [31:0]   waiting[$];
    int unsigned   byte_count;
    int unsigned   pkt_cap;
    int unsigned   byte_cap;
    queue_result_t expected_results[$];
    int            mismatches;

    function void set_register(tdpq_pkg::reg_idx_t idx, logic [31:0] value);
      if (idx == tdpq_pkg::REG_PACKET_LIMIT) pkt_cap = value[tdpq_pkg::PKT_LIM_W-1:0];
      else byte_cap = value[tdpq_pkg::BYTE_LIM_W-1:0];
    endfunction

    function queue_result_t snapshot(tdpq_pkg::action_t act, logic [15:0] tag,
                                     logic [15:0] len);
      queue_result_t r;
      r.action  = act;
      r.tag     = tag;
      r.length  = len;
      r.packets = (waiting.size() > tdpq_pkg::PKT_FIELD_MAX) ?
                  7'(tdpq_pkg::PKT_FIELD_MAX) : 7'(waiting.size());
      r.bytes   = (byte_count > tdpq_pkg::BYTE_FIELD_MAX) ?
                  22'(tdpq_pkg::BYTE_FIELD_MAX) : 22'(byte_count);
      r.busy    = tx_busy;
      return r;
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] tag, logic [15:0] len);
      queue_result_t r;
      logic [31:0]   head;
      bit            drop;
      if (op == tdpq_pkg::OP_PACKET) begin
        if (!tx_busy) begin
          tx_busy = 1'b1;
          r = snapshot(tdpq_pkg::ACT_START, tag, len);
        end else begin
          drop = waiting.size() >= tdpq_pkg::QUEUE_DEPTH;
          if (pkt_cap != 0 && waiting.size() >= pkt_cap) drop = 1'b1;
          if (byte_cap != 0 && byte_count + len > byte_cap) drop = 1'b1;
          if (drop) begin
            r = snapshot(tdpq_pkg::ACT_DROPPED, tag, len);
          end else begin
            waiting.insert(waiting.size(), {tag, len});
            byte_count += len;
            r = snapshot(tdpq_pkg::ACT_QUEUED, tag, len);
          end
        end
      end else if (op == tdpq_pkg::OP_DONE) begin
        if (waiting.size() == 0) begin
          tx_busy = 1'b0;
          r = snapshot(tdpq_pkg::ACT_IDLE, 16'h0, 16'h0);
        end else begin
          head = waiting.pop_front();
          byte_count -= head[15:0];
          tx_busy = 1'b1;
          r = snapshot(tdpq_pkg::ACT_START, head[31:16], head[15:0]);
        end
      end else begin
        r = snapshot(tdpq_pkg::ACT_CONTROL, tag, 16'h0);
      end
      expected_results.insert(expected_results.size(), r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("ERROR @%0t: %0s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(queue_result_t got);
      queue_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending, tag", got.tag, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.action != want.action) report_mismatch("action", got.action, want.action);
        if (got.tag != want.tag) report_mismatch("out_tag", got.tag, want.tag);
        if (got.length != want.length) report_mismatch("out_length", got.length, want.length);
        if (got.packets != want.packets)
          report_mismatch("out_queued_packets", got.packets, want.packets);
        if (got.bytes != want.bytes) report_mismatch("out_queued_bytes", got.bytes, want.bytes);
        if (got.busy != want.busy) report_mismatch("out_busy_res", got.busy, want.busy);
      end
    endtask
  endclass

  logic                          clk              = 1'b0;
  logic                          rst_n            = 1'b0;
  logic                          in_valid         = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_op            = '0;
  logic [15:0]                   in_packet_tag    = '0;
  logic [15:0]                   in_packet_length = '0;
  logic                          out_valid;
  logic                          out_ready        = 1'b0;
  logic [2:0]                    out_action;
  logic [15:0]                   out_tag;
  logic [15:0]                   out_length;
  logic [6:0]                    out_queued_packets;
  logic [21:0]                   out_queued_bytes;
  logic                          out_busy_res;
  logic                          psel             = 1'b0;
  logic                          penable          = 1'b0;
  logic                          pwrite           = 1'b0;
  logic [tdpq_pkg::PADDR_W-1:0]  paddr            = '0;
  logic [tdpq_pkg::PDATA_W-1:0]  pwdata           = '0;
  logic [tdpq_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  port_queue_model queue_model = new;
  bit              fast_phase  = 1'b0;
  int              items_sent  = 0;

  tail_drop_port_queue_unit uut (.*);

  always #2 clk = ~clk;

  function automatic int draw_wait();
    return fast_phase ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic logic [15:0] draw_length();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0;
    if (pick == 1) return 16'hFFFF;
    if (pick < 5) return 16'($urandom_range(1, 1500));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [1:0] draw_op(int pkt_pct, int done_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < pkt_pct) return tdpq_pkg::OP_PACKET;
    if (r < pkt_pct + done_pct) return tdpq_pkg::OP_DONE;
    return r[0] ? tdpq_pkg::OP_CONTROL : OP_RESERVED;
  endfunction

  task automatic send_request(logic [1:0] op, logic [15:0] tag, logic [15:0] len);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_packet_tag    <= tag;
    in_packet_length <= len;
    do @(posedge clk); while (!in_ready);
    queue_model.note_request(op, tag, len);
    items_sent++;
  endtask

  // hold off new requests until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (queue_model.pending() > 0);
  endtask

  task automatic write_register(tdpq_pkg::reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    queue_model.set_register(idx, value);
  endtask

  task automatic reconfigure();
    logic [31:0] value;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0: value = 0;
        1: value = 1;
        2: value = 64;
        default: value = $urandom_range(1, 64);
      endcase
      write_register(tdpq_pkg::REG_PACKET_LIMIT, value);
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 4))
        0: value = 0;
        1: value = 1;
        2: value = tdpq_pkg::BYTE_FIELD_MAX;
        3: value = $urandom_range(1, 200000);
        default: value = $urandom_range(0, tdpq_pkg::BYTE_FIELD_MAX);
      endcase
      write_register(tdpq_pkg::REG_BYTE_LIMIT, value);
    end
  endtask

  task automatic run_phase(int count, int pkt_pct, int done_pct);
    repeat (count)
      send_request(draw_op(pkt_pct, done_pct), 16'($urandom_range(0, 65535)), draw_length());
  endtask

  initial begin : result_sink
    queue_result_t got;
    int            stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.action  = tdpq_pkg::action_t'(out_action);
      got.tag     = out_tag;
      got.length  = out_length;
      got.packets = out_queued_packets;
      got.bytes   = out_queued_bytes;
      got.busy    = out_busy_res;
      queue_model.check_result(got);
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // done while idle, control, reserved selector, then a short queue
    send_request(tdpq_pkg::OP_DONE, 16'h1234, 16'h0007);
    send_request(tdpq_pkg::OP_CONTROL, 16'hFFFF, 16'hFFFF);
    send_request(OP_RESERVED, 16'h0000, 16'h0000);
    send_request(tdpq_pkg::OP_PACKET, 16'h0000, 16'h0000);
    send_request(tdpq_pkg::OP_PACKET, 16'hFFFF, 16'hFFFF);
    send_request(tdpq_pkg::OP_PACKET, 16'h00AA, 16'h0000);
    send_request(tdpq_pkg::OP_CONTROL, 16'h5A5A, 16'h1111);
    send_request(tdpq_pkg::OP_DONE, 16'h0000, 16'h0000);
    send_request(tdpq_pkg::OP_DONE, 16'hFFFF, 16'hFFFF);
    send_request(tdpq_pkg::OP_DONE, 16'h0000, 16'h0000);

    drain();
    write_register(tdpq_pkg::REG_PACKET_LIMIT, 1);
    send_request(tdpq_pkg::OP_PACKET, 16'h0101, 16'h0040);
    send_request(tdpq_pkg::OP_PACKET, 16'h0202, 16'h0041);
    send_request(tdpq_pkg::OP_PACKET, 16'h0303, 16'h0042);
    send_request(tdpq_pkg::OP_DONE, 16'h0000, 16'h0000);
    send_request(tdpq_pkg::OP_DONE, 16'h0000, 16'h0000);

    drain();
    write_register(tdpq_pkg::REG_PACKET_LIMIT, 0);
    write_register(tdpq_pkg::REG_BYTE_LIMIT, 100);
    send_request(tdpq_pkg::OP_PACKET, 16'h0A0A, 16'hFFFF);
    send_request(tdpq_pkg::OP_PACKET, 16'h0B0B, 16'd100);
    send_request(tdpq_pkg::OP_PACKET, 16'h0C0C, 16'd0);
    send_request(tdpq_pkg::OP_PACKET, 16'h0D0D, 16'd1);
    send_request(tdpq_pkg::OP_DONE, 16'h0000, 16'h0000);
    send_request(tdpq_pkg::OP_DONE, 16'h0000, 16'h0000);
    send_request(tdpq_pkg::OP_DONE, 16'h0000, 16'h0000);

    // overfill the FIFO with no limits, then packet limit 64, largest byte limit
    drain();
    write_register(tdpq_pkg::REG_BYTE_LIMIT, 0);
    run_phase(70, 100, 0);
    run_phase(70, 0, 100);
    drain();
    write_register(tdpq_pkg::REG_PACKET_LIMIT, 64);
    write_register(tdpq_pkg::REG_BYTE_LIMIT, tdpq_pkg::BYTE_FIELD_MAX);
    fast_phase = 1'b1;
    run_phase(68, 100, 0);
    fast_phase = 1'b0;
    run_phase(68, 0, 100);

    while (items_sent < 1400) begin
      drain();
      reconfigure();
      fast_phase = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: run_phase($urandom_range(30, 120), 70, 25);
        1: run_phase($urandom_range(30, 120), 25, 70);
        default: run_phase($urandom_range(30, 120), 45, 45);
      endcase
    end

    fast_phase = 1'b0;
    drain();
    repeat (4) @(posedge clk);
    if (queue_model.mismatches == 0 && queue_model.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
src/tdpq_pkg.sv
src/tdpq_ram.sv
src/tdpq_regs.sv
src/tail_drop_port_queue_unit.sv
bench/tb_top.sv
